[design/rsi_pkg.sv]
package rsi_pkg;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_CENTER_X = 3'd0,
        CFG_CENTER_Y = 3'd1,
        CFG_CENTER_Z = 3'd2,
        CFG_RADIUS   = 3'd3,
        CFG_MARGIN   = 3'd4
    } t_cfg_reg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [30:0] RADIUS_RST = 31'd65536;
    localparam logic [30:0] MARGIN_RST = 31'd6554;

    // datapath widths
    localparam int SUM_W  = 66;    // rel.rel, |h|, |c|
    localparam int DISC_W = 132;   // quarter discriminant magnitude
    localparam int TMUL_W = 68;    // |d| * n operands
    localparam int NUM_W  = 99;    // |d| * n product bits in use
    localparam int DEN_W  = 64;    // d.d
    localparam int QUO_W  = 34;    // offset bits kept; larger saturates anyway

    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN = -32'sh7FFF_FFFF - 32'sd1;

    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        logic signed [31:0] r;
        if (v > 40'sh00_7FFF_FFFF) begin
            r = Q_MAX;
        end else if (v < -40'sh00_8000_0000) begin
            r = Q_MIN;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

[design/rsi_dly.sv]
module rsi_dly #(
    parameter int W = 1,
    parameter int N = 1
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_d
);

    logic [W-1:0] r_sh [N];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sh[0] <= i_d;
            for (int k = 1; k < N; k++) begin
                r_sh[k] <= r_sh[k-1];
            end
        end
    end

    assign o_d = r_sh[N-1];

endmodule

[design/rsi_mul.sv]
module rsi_mul #(
    parameter int W = 66
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  logic [W-1:0]   i_a,
    input  logic [W-1:0]   i_b,
    output logic [2*W-1:0] o_p
);

    localparam int H = W / 2;

    logic [2*H-1:0] r_ll, r_lh, r_hl, r_hh;
    logic [2*W-1:0] r_p;
    logic [2*W-1:0] n_mid;
    logic [2*W-1:0] n_p;

    // four half-width partial products, summed in the next stage
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ll <= i_a[H-1:0] * i_b[H-1:0];
            r_lh <= i_a[H-1:0] * i_b[W-1:H];
            r_hl <= i_a[W-1:H] * i_b[H-1:0];
            r_hh <= i_a[W-1:H] * i_b[W-1:H];
            r_p  <= n_p;
        end
    end

    always_comb begin
        n_mid = {{(H-1){1'b0}}, ({1'b0, r_lh} + {1'b0, r_hl}), {H{1'b0}}};
        n_p   = {r_hh, r_ll} + n_mid;
    end

    assign o_p = r_p;

endmodule

[design/rsi_isqrt.sv]
module rsi_isqrt #(
    parameter int W = 66
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  logic [W-1:0]   i_x,
    output logic [W/2-1:0] o_root
);

    localparam int N = W / 2;

    logic [N+1:0] r_rem  [N];
    logic [N-1:0] r_root [N];
    logic [W-1:0] r_x    [N];

    // one result bit per stage, two radicand bits shifted in each time
    for (genvar k = 0; k < N; k++) begin : g_stage
        logic [N+1:0] rem_in;
        logic [N-1:0] root_in;
        logic [W-1:0] x_in;
        logic [N+3:0] tmp;
        logic [N+3:0] trial;
        logic [N+3:0] diff;
        logic         ge;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign x_in    = i_x;
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
            assign x_in    = r_x[k-1];
        end

        always_comb begin
            tmp   = {rem_in, x_in[W-1:W-2]};
            trial = {2'b00, root_in, 2'b01};
            diff  = tmp - trial;
            ge    = (tmp >= trial);
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= ge ? diff[N+1:0] : tmp[N+1:0];
                r_root[k] <= {root_in[N-2:0], ge};
                r_x[k]    <= {x_in[W-3:0], 2'b00};
            end
        end
    end

    assign o_root = r_root[N-1];

endmodule

[design/rsi_div.sv]
module rsi_div #(
    parameter int NW = 99,
    parameter int DW = 64,
    parameter int QW = 34
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [QW-1:0] o_quo,
    output logic          o_ovf
);

    localparam int HW = NW - QW;

    logic [DW-1:0] r_rem [QW+1];
    logic [QW-1:0] r_lo  [QW+1];
    logic [DW-1:0] r_den [QW+1];
    logic          r_ovf [QW+1];

    logic [HW-1:0] n_hi;

    // quotient of QW bits or more flags overflow up front
    assign n_hi = i_num[NW-1:QW];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= n_hi[DW-1:0];
            r_lo[0]  <= i_num[QW-1:0];
            r_den[0] <= i_den;
            r_ovf[0] <= (n_hi >= HW'(i_den));
        end
    end

    // restoring steps; quotient bits shift into the low dividend word
    for (genvar k = 1; k <= QW; k++) begin : g_step
        logic [DW:0] t;
        logic [DW:0] sub;
        logic        ge;

        always_comb begin
            t   = {r_rem[k-1], r_lo[k-1][QW-1]};
            sub = t - {1'b0, r_den[k-1]};
            ge  = (t >= {1'b0, r_den[k-1]});
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= ge ? sub[DW-1:0] : t[DW-1:0];
                r_lo[k]  <= {r_lo[k-1][QW-2:0], ge};
                r_den[k] <= r_den[k-1];
                r_ovf[k] <= r_ovf[k-1];
            end
        end
    end

    assign o_quo = r_lo[QW];
    assign o_ovf = r_ovf[QW];

endmodule

[design/ray_sphere_intersect.sv]
// Throughput: one ray per cycle unless the output stalls; the critical depth is one root bit per stage
// in the two square root pipelines and one quotient bit per stage in the dividers.
// Backpressure on the output holds the whole pipeline in place.
// Reset (synchronous, active low) clears all valid bits and sets the centre to 0,
// radius to 1.0 and margin to about 0.1; pipeline data is not reset.
module ray_sphere_intersect import rsi_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
    input  logic [191:0]          s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // point_x, point_y, point_z, normal_x, normal_y, normal_z
    output logic [191:0]          m_axis_tdata,
    // hit
    output logic                  m_axis_tuser
);

    localparam int LAT = 113;

    logic              en;
    logic [LAT:1]      r_vld;

    logic signed [31:0] r_ctr [3];
    logic [30:0]        r_rad;
    logic [30:0]        r_margin;
    logic [61:0]        r_rsq;

    // config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctr[0] <= '0;
            r_ctr[1] <= '0;
            r_ctr[2] <= '0;
            r_rad    <= RADIUS_RST;
            r_margin <= MARGIN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CENTER_X: r_ctr[0] <= i_cfg_data;
                CFG_CENTER_Y: r_ctr[1] <= i_cfg_data;
                CFG_CENTER_Z: r_ctr[2] <= i_cfg_data;
                CFG_RADIUS:   r_rad    <= i_cfg_data[30:0];
                CFG_MARGIN:   r_margin <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_rsq <= r_rad * r_rad;
    end

    assign en            = !r_vld[LAT] || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = r_vld[LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-1:1], s_axis_tvalid};
        end
    end

    // stage 1: relative origin
    logic signed [32:0] r_rel1 [3];
    logic signed [31:0] r_d1   [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_rel1[i] <= $signed({s_axis_tdata[32*i+31], s_axis_tdata[32*i +: 32]})
                           - $signed({r_ctr[i][31], r_ctr[i]});
                r_d1[i]   <= s_axis_tdata[96+32*i +: 32];
            end
        end
    end

    // stage 2: products
    logic [63:0]        r_rr2 [3];
    logic [63:0]        r_dd2 [3];
    logic signed [63:0] r_rd2 [3];
    logic signed [65:0] n_rr  [3];
    logic signed [65:0] n_dd  [3];
    logic signed [65:0] n_rd  [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_rr[i] = r_rel1[i] * r_rel1[i];
            n_dd[i] = r_d1[i] * r_d1[i];
            n_rd[i] = r_rel1[i] * r_d1[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_rr2[i] <= n_rr[i][63:0];
                r_dd2[i] <= n_dd[i][63:0];
                r_rd2[i] <= n_rd[i][63:0];
            end
        end
    end

    // stage 3: dot products
    logic [SUM_W-1:0]        r_s3;
    logic [DEN_W-1:0]        r_a3;
    logic signed [SUM_W-1:0] r_h3;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s3 <= {2'b00, r_rr2[0]} + {2'b00, r_rr2[1]} + {2'b00, r_rr2[2]};
            r_a3 <= r_dd2[0] + r_dd2[1] + r_dd2[2];
            r_h3 <= SUM_W'(r_rd2[0]) + SUM_W'(r_rd2[1]) + SUM_W'(r_rd2[2]);
        end
    end

    // stage 4: c = S - R^2, magnitudes for the wide multipliers
    logic signed [67:0] n_c;
    logic [67:0]        n_cneg;
    logic [SUM_W-1:0]   n_hneg;
    logic [SUM_W-1:0]   r_cmag4;
    logic               r_cneg4;
    logic [SUM_W-1:0]   r_hmag4;
    logic [SUM_W-1:0]   r_a4;

    always_comb begin
        n_c    = $signed({2'b00, r_s3}) - $signed({6'd0, r_rsq});
        n_cneg = -n_c;
        n_hneg = -r_h3;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cmag4 <= n_c[67] ? n_cneg[SUM_W-1:0] : n_c[SUM_W-1:0];
            r_cneg4 <= n_c[67];
            r_hmag4 <= r_h3[SUM_W-1] ? n_hneg : r_h3;
            r_a4    <= {2'b00, r_a3};
        end
    end

    // stages 5-6: h^2 and a*|c|
    logic [2*SUM_W-1:0] hsq6;
    logic [2*SUM_W-1:0] ac6;
    logic               cneg6;

    rsi_mul #(.W(SUM_W)) u_mul_hh (
        .i_clk (i_clk), .i_en (en), .i_a (r_hmag4), .i_b (r_hmag4), .o_p (hsq6)
    );

    rsi_mul #(.W(SUM_W)) u_mul_ac (
        .i_clk (i_clk), .i_en (en), .i_a (r_a4), .i_b (r_cmag4), .o_p (ac6)
    );

    rsi_dly #(.W(1), .N(2)) u_dly_cneg (
        .i_clk (i_clk), .i_en (en), .i_d (r_cneg4), .o_d (cneg6)
    );

    // stage 7: quarter discriminant
    logic [DISC_W:0]   n_dsum;
    logic [DISC_W:0]   n_ddif;
    logic [DISC_W-1:0] r_dmag7;
    logic              r_dneg7;

    always_comb begin
        n_dsum = {1'b0, hsq6} + {1'b0, ac6};
        n_ddif = {1'b0, hsq6} - {1'b0, ac6};
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dmag7 <= cneg6 ? n_dsum[DISC_W-1:0] : n_ddif[DISC_W-1:0];
            r_dneg7 <= !cneg6 && (hsq6 < ac6);
        end
    end

    // origin distance check: sqrt(S) at stage 36, compare at 37
    logic [SUM_W/2-1:0] dist36;
    logic signed [33:0] n_ddist;
    logic [33:0]        n_dabs;
    logic               r_rej37;
    logic               rej73;

    rsi_isqrt #(.W(SUM_W)) u_sqrt_s (
        .i_clk (i_clk), .i_en (en), .i_x (r_s3), .o_root (dist36)
    );

    always_comb begin
        n_ddist = $signed({1'b0, dist36}) - $signed({3'b000, r_rad});
        n_dabs  = n_ddist[33] ? -n_ddist : n_ddist;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rej37 <= (n_dabs < {3'b000, r_margin});
        end
    end

    rsi_dly #(.W(1), .N(36)) u_dly_rej (
        .i_clk (i_clk), .i_en (en), .i_d (r_rej37), .o_d (rej73)
    );

    // sqrt(D) at stage 73, operands carried alongside
    logic [DISC_W/2-1:0]     s73;
    logic                    dneg73;
    logic [SUM_W+DEN_W-1:0]  ha73;
    logic [191:0]            od73;
    logic signed [SUM_W-1:0] h73;
    logic [DEN_W-1:0]        a73;

    rsi_isqrt #(.W(DISC_W)) u_sqrt_d (
        .i_clk (i_clk), .i_en (en), .i_x (r_dmag7), .o_root (s73)
    );

    rsi_dly #(.W(1), .N(66)) u_dly_dneg (
        .i_clk (i_clk), .i_en (en), .i_d (r_dneg7), .o_d (dneg73)
    );

    rsi_dly #(.W(SUM_W+DEN_W), .N(70)) u_dly_ha (
        .i_clk (i_clk), .i_en (en), .i_d ({r_h3, r_a3}), .o_d (ha73)
    );

    rsi_dly #(.W(192), .N(73)) u_dly_od (
        .i_clk (i_clk), .i_en (en), .i_d (s_axis_tdata), .o_d (od73)
    );

    assign h73 = ha73[SUM_W+DEN_W-1:DEN_W];
    assign a73 = ha73[DEN_W-1:0];

    // stage 74: root choice
    logic signed [67:0] n_hx;
    logic signed [67:0] n_n2;
    logic signed [67:0] n_n1;
    logic               n_p2;
    logic               n_p1;
    logic [66:0]        r_n74;
    logic               r_hit74;
    logic [DEN_W-1:0]   r_a74;
    logic [31:0]        r_dmag74 [3];
    logic [2:0]         r_dneg74;
    logic [31:0]        r_o74    [3];

    always_comb begin
        n_hx = {{2{h73[SUM_W-1]}}, h73};
        n_n2 = -n_hx - $signed({2'b00, s73});
        n_n1 = $signed({2'b00, s73}) - n_hx;
        n_p2 = !n_n2[67] && (n_n2 != '0);
        n_p1 = !n_n1[67] && (n_n1 != '0);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_n74   <= n_p2 ? n_n2[66:0] : n_n1[66:0];
            r_hit74 <= !rej73 && !dneg73 && (a73 != '0) && (n_p2 || n_p1);
            r_a74   <= a73;
            for (int i = 0; i < 3; i++) begin
                r_dmag74[i] <= od73[96+32*i+31] ? (~od73[96+32*i +: 32] + 32'd1)
                                                : od73[96+32*i +: 32];
                r_dneg74[i] <= od73[96+32*i+31];
                r_o74[i]    <= od73[32*i +: 32];
            end
        end
    end

    // stages 75-111: |d|*n / a per lane
    logic [DEN_W-1:0] a76;
    logic [QUO_W-1:0] q111   [3];
    logic [2:0]       ovf111;
    logic [99:0]      side111;

    rsi_dly #(.W(DEN_W), .N(2)) u_dly_a (
        .i_clk (i_clk), .i_en (en), .i_d (r_a74), .o_d (a76)
    );

    for (genvar i = 0; i < 3; i++) begin : g_lane
        logic [2*TMUL_W-1:0] prod76;

        rsi_mul #(.W(TMUL_W)) u_mul_t (
            .i_clk (i_clk),
            .i_en  (en),
            .i_a   ({{(TMUL_W-32){1'b0}}, r_dmag74[i]}),
            .i_b   ({1'b0, r_n74}),
            .o_p   (prod76)
        );

        rsi_div #(.NW(NUM_W), .DW(DEN_W), .QW(QUO_W)) u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (prod76[NUM_W-1:0]),
            .i_den (a76),
            .o_quo (q111[i]),
            .o_ovf (ovf111[i])
        );
    end

    rsi_dly #(.W(100), .N(37)) u_dly_side (
        .i_clk (i_clk),
        .i_en  (en),
        .i_d   ({r_hit74, r_dneg74, r_o74[2], r_o74[1], r_o74[0]}),
        .o_d   (side111)
    );

    // stage 112: hit point, truncated toward zero
    logic signed [36:0] n_off  [3];
    logic signed [36:0] r_p112 [3];
    logic [2:0]         r_povf112;
    logic [2:0]         r_pneg112;
    logic               r_hit112;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_off[i] = side111[96+i] ? -$signed({3'b000, q111[i]})
                                     : $signed({3'b000, q111[i]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_p112[i] <= n_off[i] + 37'($signed(side111[32*i +: 32]));
            end
            r_povf112 <= ovf111;
            r_pneg112 <= side111[98:96];
            r_hit112  <= side111[99];
        end
    end

    // stage 113: normal and saturation
    logic signed [37:0] n_nm  [3];
    logic               r_hit_o;
    logic signed [31:0] r_pt_o [3];
    logic signed [31:0] r_nm_o [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_nm[i] = 38'(r_ctr[i]) - 38'(r_p112[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_hit_o <= r_hit112;
            for (int i = 0; i < 3; i++) begin
                if (!r_hit112) begin
                    r_pt_o[i] <= '0;
                    r_nm_o[i] <= '0;
                end else if (r_povf112[i]) begin
                    r_pt_o[i] <= r_pneg112[i] ? Q_MIN : Q_MAX;
                    r_nm_o[i] <= r_pneg112[i] ? Q_MAX : Q_MIN;
                end else begin
                    r_pt_o[i] <= sat32(40'(r_p112[i]));
                    r_nm_o[i] <= sat32(40'(n_nm[i]));
                end
            end
        end
    end

    assign m_axis_tuser = r_hit_o;
    assign m_axis_tdata = {r_nm_o[2], r_nm_o[1], r_nm_o[0],
                           r_pt_o[2], r_pt_o[1], r_pt_o[0]};

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
        else $error("miss transaction with nonzero data");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_vld))
        else $error("valid pipeline moved during stall");

    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_stall_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_p112[0]) && $stable(r_hit112))
        else $error("pipeline data moved during stall");

endmodule

[sim/ray_hit_checker.sv]
`timescale 1ns / 1ps

module ray_hit_checker import rsi_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_ray_valid,
    input  logic                  i_ray_ready,
    input  logic [191:0]          i_ray_data,
    input  logic                  i_hit_valid,
    input  logic                  i_hit_ready,
    input  logic [191:0]          i_hit_data,
    input  logic                  i_hit_flag,
    output int                    o_fail_count,
    output int                    o_hits_pending
);

    typedef logic signed [255:0] wide_t;

    typedef struct {
        logic        hit;
        logic [31:0] field [6];   // point x,y,z then normal x,y,z
    } hit_info_t;

    logic signed [31:0] sph_center [3];
    logic [30:0]        sph_radius;
    logic [30:0]        sph_margin;
    hit_info_t          hits_expected [$];

    function automatic wide_t floor_sqrt(input wide_t x);
        wide_t r;
        wide_t c;
        r = '0;
        for (int b = 100; b >= 0; b--) begin
            c = r | (wide_t'(1) << b);
            if (c * c <= x) r = c;
        end
        return r;
    endfunction

    function automatic logic [31:0] clamp_q(input wide_t v);
        logic [31:0] r;
        if (v > wide_t'(32'sh7FFF_FFFF)) r = 32'h7FFF_FFFF;
        else if (v < wide_t'(-64'sh8000_0000)) r = 32'h8000_0000;
        else r = v[31:0];
        return r;
    endfunction

    function automatic hit_info_t trace_ray(input logic [191:0] ray);
        hit_info_t          res;
        logic signed [31:0] org [3];
        logic signed [31:0] dir [3];
        wide_t rel [3];
        wide_t dw [3];
        wide_t s2, a2, h2, rad, org_dist, diff, c2, disc, root, num, mag, off, p;
        res.hit = 1'b0;
        for (int i = 0; i < 6; i++) res.field[i] = '0;
        s2 = '0;
        a2 = '0;
        h2 = '0;
        for (int i = 0; i < 3; i++) begin
            org[i] = ray[32*i +: 32];
            dir[i] = ray[96 + 32*i +: 32];
            rel[i] = wide_t'(org[i]) - wide_t'(sph_center[i]);
            dw[i]  = wide_t'(dir[i]);
            s2 += rel[i] * rel[i];
            a2 += dw[i] * dw[i];
            h2 += rel[i] * dw[i];
        end
        rad      = wide_t'(sph_radius);
        org_dist = floor_sqrt(s2);
        diff     = org_dist - rad;
        if (diff < 0) diff = -diff;
        if (diff < wide_t'(sph_margin)) return res;
        c2   = s2 - rad * rad;
        disc = h2 * h2 - a2 * c2;
        if (disc < 0 || a2 == 0) return res;
        root = floor_sqrt(disc);
        num  = -h2 - root;
        if (num <= 0) begin
            num = root - h2;
            if (num <= 0) return res;
        end
        res.hit = 1'b1;
        for (int i = 0; i < 3; i++) begin
            mag = (dw[i] < 0) ? -dw[i] : dw[i];
            off = (mag * num) / a2;
            if (dw[i] < 0) off = -off;
            p = wide_t'(org[i]) + off;
            res.field[i]     = clamp_q(p);
            res.field[3 + i] = clamp_q(wide_t'(sph_center[i]) - p);
        end
        return res;
    endfunction

    assign o_hits_pending = hits_expected.size();

    always @(posedge i_clk) begin
        hit_info_t want;
        int        errs;
        errs = 0;
        if (!i_rst_n) begin
            sph_center[0] <= '0;
            sph_center[1] <= '0;
            sph_center[2] <= '0;
            sph_radius    <= RADIUS_RST;
            sph_margin    <= MARGIN_RST;
            o_fail_count  <= 0;
            hits_expected.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_CENTER_X: sph_center[0] <= i_cfg_data;
                    CFG_CENTER_Y: sph_center[1] <= i_cfg_data;
                    CFG_CENTER_Z: sph_center[2] <= i_cfg_data;
                    CFG_RADIUS:   sph_radius    <= i_cfg_data[30:0];
                    CFG_MARGIN:   sph_margin    <= i_cfg_data[30:0];
                    default: ;
                endcase
            end
            if (i_ray_valid && i_ray_ready) hits_expected.push_back(trace_ray(i_ray_data));
            if (i_hit_valid && i_hit_ready) begin
                if (hits_expected.size() == 0) begin
                    $display("%0t: result transaction with nothing expected: hit %0b data %h",
                             $time, i_hit_flag, i_hit_data);
                    errs++;
                end else begin
                    want = hits_expected.pop_front();
                    if (want.hit !== i_hit_flag) begin
                        $display("%0t: hit expected %0b actual %0b", $time, want.hit, i_hit_flag);
                        errs++;
                    end
                    for (int i = 0; i < 6; i++) begin
                        if (want.field[i] !== i_hit_data[32*i +: 32]) begin
                            $display("%0t: field %0d expected %h actual %h", $time, i,
                                     want.field[i], i_hit_data[32*i +: 32]);
                            errs++;
                        end
                    end
                end
            end
            o_fail_count <= o_fail_count + errs;
        end
    end

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps

module testbench import rsi_pkg::*;;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
    localparam int IDLE_LIMIT = 5000;
    localparam int LONG_HOLD  = 400;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [191:0]          s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [191:0]          m_axis_tdata;
    logic                  m_axis_tuser;

    int  fail_count;
    int  hits_pending;
    int  idle_cycles = 0;
    bit  no_idle = 1'b0;
    bit  hold_request = 1'b0;
    logic signed [31:0] cur_center [3] = '{0, 0, 0};
    logic [30:0]        cur_radius = RADIUS_RST;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    ray_sphere_intersect dut (.*);

    ray_hit_checker checker_inst (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_ray_valid(s_axis_tvalid), .i_ray_ready(s_axis_tready), .i_ray_data(s_axis_tdata),
        .i_hit_valid(m_axis_tvalid), .i_hit_ready(m_axis_tready), .i_hit_data(m_axis_tdata),
        .i_hit_flag(m_axis_tuser),
        .o_fail_count(fail_count), .o_hits_pending(hits_pending)
    );

    // watchdog: cycles without any transaction on either stream
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // result side
    initial begin
        int stall;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                m_axis_tready = 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                hold_request = 1'b0;
            end
            stall = no_idle ? 0 : $urandom_range(0, 18);
            if (stall > 0) begin
                m_axis_tready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready = 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        if (idx == CFG_CENTER_X) cur_center[0] = val;
        if (idx == CFG_CENTER_Y) cur_center[1] = val;
        if (idx == CFG_CENTER_Z) cur_center[2] = val;
        if (idx == CFG_RADIUS)   cur_radius = val[30:0];
    endtask

    task automatic set_sphere(input logic [31:0] cx, cy, cz, rad, margin);
        write_reg(CFG_CENTER_X, cx);
        write_reg(CFG_CENTER_Y, cy);
        write_reg(CFG_CENTER_Z, cz);
        write_reg(CFG_RADIUS, rad);
        write_reg(CFG_MARGIN, margin);
    endtask

    // called right after a falling edge
    task automatic send_ray(input logic [31:0] ox, oy, oz, dx, dy, dz);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {dz, dy, dx, oz, oy, ox};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // called right after a falling edge
    task automatic drain;
        s_axis_tvalid = 1'b0;
        while (hits_pending != 0) @(negedge i_clk);
    endtask

    function automatic logic [31:0] clip32(input longint v);
        if (v > 64'sh7FFF_FFFF) return 32'h7FFF_FFFF;
        if (v < -64'sh8000_0000) return 32'h8000_0000;
        return v[31:0];
    endfunction

    function automatic longint rand_span(input longint span);
        return longint'({$urandom, $urandom}) % (2 * span + 1) - span;
    endfunction

    // rays from near the sphere, aimed at it or directly away, plus full-range and small-range noise
    task automatic random_ray;
        longint scale;
        longint org [3];
        logic [31:0] o [3];
        logic [31:0] d [3];
        int kind;
        kind  = $urandom_range(0, 9);
        scale = (cur_radius == 0) ? 65536 : longint'(cur_radius);
        for (int i = 0; i < 3; i++) begin
            if (kind < 6) begin
                org[i] = longint'(cur_center[i]) + rand_span(4 * scale);
                o[i]   = clip32(org[i]);
                d[i]   = clip32(longint'(cur_center[i]) + rand_span(scale)
                                - longint'($signed(o[i])));
                if (kind == 5) d[i] = -d[i];
            end else if (kind < 8) begin
                o[i] = $urandom;
                d[i] = $urandom;
            end else begin
                o[i] = clip32(rand_span(8 * 65536));
                d[i] = clip32(rand_span(4 * 65536));
            end
        end
        send_ray(o[0], o[1], o[2], d[0], d[1], d[2]);
    endtask

    localparam logic [31:0] ONE  = 32'h0001_0000;
    localparam logic [31:0] MONE = 32'hFFFF_0000;
    localparam logic [31:0] PMAX = 32'h7FFF_FFFF;
    localparam logic [31:0] NMIN = 32'h8000_0000;

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed, reset sphere: unit radius at the origin
        send_ray(0, 0, -5 * ONE, 0, 0, ONE);          // straight hit, near root
        send_ray(0, 0, 0, ONE, 0, 0);                 // from inside, far root
        send_ray(ONE, 0, 0, ONE, 0, 0);               // origin on the surface
        send_ray(0, 2 * ONE, -5 * ONE, 0, 0, ONE);    // negative discriminant
        send_ray(0, 0, -5 * ONE, 0, 0, 0);            // zero direction
        send_ray(0, 0, -5 * ONE, 0, 0, MONE);         // sphere behind the ray
        send_ray(0, ONE, -5 * ONE, 0, 0, ONE);        // grazing
        send_ray(PMAX, PMAX, PMAX, NMIN, NMIN, NMIN);
        send_ray(NMIN, NMIN, NMIN, PMAX, PMAX, PMAX);
        send_ray(NMIN, PMAX, 0, PMAX, NMIN, 32'h1);
        send_ray(0, 0, -3 * ONE, 0, 0, 32'h1);        // tiny direction
        drain();

        // zero margin, zero radius, unused index
        set_sphere(ONE, MONE, 0, 0, 0);
        write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
        send_ray(ONE, MONE, -ONE, 0, 0, ONE);         // ray through a point sphere
        send_ray(2 * ONE, MONE, 0, MONE, 0, 0);
        send_ray(ONE, MONE, 0, ONE, 0, 0);            // origin at the centre
        drain();

        // extreme sphere: saturated points and normals
        set_sphere(PMAX, NMIN, PMAX, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_ray(0, 0, 0, ONE, MONE, ONE);
        send_ray(NMIN, PMAX, NMIN, PMAX, NMIN, PMAX);
        drain();
        write_reg(CFG_MARGIN, 0);
        send_ray(0, 0, 0, ONE, MONE, ONE);
        send_ray(NMIN, PMAX, NMIN, PMAX, NMIN, PMAX);
        send_ray(PMAX, NMIN, PMAX, ONE, 0, 0);
        drain();

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: set_sphere(0, 0, 0, {1'b0, RADIUS_RST}, {1'b0, MARGIN_RST});
                1: set_sphere(3 * ONE, -2 * ONE, 7 * ONE, 3 * ONE, 0);
                2: set_sphere(NMIN, NMIN, NMIN, 32'h7FFF_FFFF, 0);
                3: set_sphere(PMAX, PMAX, PMAX, 32'h0100_0000, 32'h7FFF_FFFF);
                4: set_sphere($urandom, $urandom, $urandom, $urandom_range(0, 32'h7FFF_FFFF),
                              $urandom_range(0, 32'h7FFF));
                default: set_sphere($urandom_range(0, 32'hFFFFF), 0, MONE, ONE / 4,
                                    $urandom_range(0, 32'hFFFF));
            endcase
            @(negedge i_clk);
            for (int k = 0; k < 150; k++) begin
                if (k % 50 == 0) no_idle = ($urandom_range(0, 2) == 0);
                if (phase == 1 && k == 20) begin
                    no_idle = 1'b1;
                    hold_request = 1'b1;
                end
                random_ray();
            end
            no_idle = 1'b0;
            drain();
        end

        repeat (150) @(posedge i_clk);
        if (fail_count == 0 && hits_pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

[files.f]
design/rsi_pkg.sv
design/rsi_dly.sv
design/rsi_mul.sv
design/rsi_isqrt.sv
design/rsi_div.sv
design/ray_sphere_intersect.sv
sim/ray_hit_checker.sv
sim/testbench.sv
